### design/obb_pkg.sv
package obb_pkg;

  // default geometry of the coordinate and axis formats
  localparam int COORD_WIDTH_DEF    = 24;
  localparam int AXIS_FRAC_BITS_DEF = 14;

endpackage

### design/obb_box_if.sv
interface obb_box_if #(
  parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
  parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_BITS_DEF
);
  localparam int AW = AXIS_FRAC_BITS + 2;
  localparam int HW = COORD_WIDTH - 1;

  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] a_center_x;
  logic signed [COORD_WIDTH-1:0] a_center_y;
  logic signed [AW-1:0]          a_axis_cos;
  logic signed [AW-1:0]          a_axis_sin;
  logic        [HW-1:0]          a_half_width;
  logic        [HW-1:0]          a_half_height;
  logic signed [COORD_WIDTH-1:0] b_center_x;
  logic signed [COORD_WIDTH-1:0] b_center_y;
  logic signed [AW-1:0]          b_axis_cos;
  logic signed [AW-1:0]          b_axis_sin;
  logic        [HW-1:0]          b_half_width;
  logic        [HW-1:0]          b_half_height;

  modport source (
    output valid, a_center_x, a_center_y, a_axis_cos, a_axis_sin, a_half_width,
           a_half_height, b_center_x, b_center_y, b_axis_cos, b_axis_sin,
           b_half_width, b_half_height,
    input  ready
  );

  modport sink (
    input  valid, a_center_x, a_center_y, a_axis_cos, a_axis_sin, a_half_width,
           a_half_height, b_center_x, b_center_y, b_axis_cos, b_axis_sin,
           b_half_width, b_half_height,
    output ready
  );
endinterface

interface obb_result_if;
  logic valid;
  logic ready;
  logic overlap;

  modport source (output valid, overlap, input ready);
  modport sink   (input valid, overlap, output ready);
endinterface

### design/obb_front.sv
module obb_front #(
  parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
  parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            en,
  input  logic                                            in_valid,
  input  logic signed [COORD_WIDTH-1:0]                   a_x,
  input  logic signed [COORD_WIDTH-1:0]                   a_y,
  input  logic signed [AXIS_FRAC_BITS+1:0]                a_cos,
  input  logic signed [AXIS_FRAC_BITS+1:0]                a_sin,
  input  logic        [COORD_WIDTH-2:0]                   a_w,
  input  logic        [COORD_WIDTH-2:0]                   a_h,
  input  logic signed [COORD_WIDTH-1:0]                   b_x,
  input  logic signed [COORD_WIDTH-1:0]                   b_y,
  input  logic signed [AXIS_FRAC_BITS+1:0]                b_cos,
  input  logic signed [AXIS_FRAC_BITS+1:0]                b_sin,
  input  logic        [COORD_WIDTH-2:0]                   b_w,
  input  logic        [COORD_WIDTH-2:0]                   b_h,
  output logic                                            out_valid,
  output logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dx_ac,
  output logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dy_as,
  output logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dx_as,
  output logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dy_ac,
  output logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dx_bc,
  output logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dy_bs,
  output logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dx_bs,
  output logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dy_bc,
  output logic        [2*AXIS_FRAC_BITS+4:0]              mag_rr,
  output logic        [2*AXIS_FRAC_BITS+4:0]              mag_ru,
  output logic        [COORD_WIDTH-2:0]                   aw,
  output logic        [COORD_WIDTH-2:0]                   ah,
  output logic        [COORD_WIDTH-2:0]                   bw,
  output logic        [COORD_WIDTH-2:0]                   bh
);
  import obb_pkg::*;

  localparam int AW = AXIS_FRAC_BITS + 2;
  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = DW + AW;
  localparam int XW = 2 * AW;
  localparam int SW = XW + 1;
  localparam int HW = COORD_WIDTH - 1;

  // stage 1: center offset and axis cross products
  logic                 s1_valid;
  logic signed [DW-1:0] dx, dy;
  logic signed [XW-1:0] p_cc, p_ss, p_cs, p_sc;
  logic signed [AW-1:0] ac, as_q, bc, bs;
  logic        [HW-1:0] s1_aw, s1_ah, s1_bw, s1_bh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx    <= DW'(a_x) - DW'(b_x);
      dy    <= DW'(a_y) - DW'(b_y);
      p_cc  <= a_cos * b_cos;
      p_ss  <= a_sin * b_sin;
      p_cs  <= a_cos * b_sin;
      p_sc  <= a_sin * b_cos;
      ac    <= a_cos;
      as_q  <= a_sin;
      bc    <= b_cos;
      bs    <= b_sin;
      s1_aw <= a_w;
      s1_ah <= a_h;
      s1_bw <= b_w;
      s1_bh <= b_h;
    end
  end

  // stage 2: offset projections and magnitudes of the two distinct axis dots
  // (up.up equals right.right, up-a on right-b is minus right-a on up-b)
  logic signed [SW-1:0] ar_br, ar_bu;

  always_comb begin
    ar_br = SW'(p_cc) + SW'(p_ss);
    ar_bu = SW'(p_sc) - SW'(p_cs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_ac  <= PW'(dx * ac);
      dy_as  <= PW'(dy * as_q);
      dx_as  <= PW'(dx * as_q);
      dy_ac  <= PW'(dy * ac);
      dx_bc  <= PW'(dx * bc);
      dy_bs  <= PW'(dy * bs);
      dx_bs  <= PW'(dx * bs);
      dy_bc  <= PW'(dy * bc);
      mag_rr <= ar_br[SW-1] ? SW'(-ar_br) : SW'(ar_br);
      mag_ru <= ar_bu[SW-1] ? SW'(-ar_bu) : SW'(ar_bu);
      aw     <= s1_aw;
      ah     <= s1_ah;
      bw     <= s1_bw;
      bh     <= s1_bh;
    end
  end

endmodule

### design/obb_extent.sv
module obb_extent #(
  parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
  parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            en,
  input  logic                                            in_valid,
  input  logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dx_ac,
  input  logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dy_as,
  input  logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dx_as,
  input  logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dy_ac,
  input  logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dx_bc,
  input  logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dy_bs,
  input  logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dx_bs,
  input  logic signed [COORD_WIDTH+AXIS_FRAC_BITS+2:0]    dy_bc,
  input  logic        [2*AXIS_FRAC_BITS+4:0]              mag_rr,
  input  logic        [2*AXIS_FRAC_BITS+4:0]              mag_ru,
  input  logic        [COORD_WIDTH-2:0]                   aw,
  input  logic        [COORD_WIDTH-2:0]                   ah,
  input  logic        [COORD_WIDTH-2:0]                   bw,
  input  logic        [COORD_WIDTH-2:0]                   bh,
  output logic                                            out_valid,
  output logic [COORD_WIDTH+2*AXIS_FRAC_BITS+5:0]         lhs [4],
  output logic [COORD_WIDTH+2*AXIS_FRAC_BITS+5:0]         rhs [4]
);
  import obb_pkg::*;

  localparam int AW = AXIS_FRAC_BITS + 2;
  localparam int PW = COORD_WIDTH + 1 + AW;
  localparam int QW = PW + 1;
  localparam int SW = 2 * AW + 1;
  localparam int HW = COORD_WIDTH - 1;
  localparam int MW = HW + SW;
  localparam int CW = COORD_WIDTH + 2 * AW + 2;

  // stage 3: projection magnitudes and extent products
  logic signed [QW-1:0] d_ar, d_au, d_br, d_bu;
  logic                 s3_valid;
  logic        [QW-1:0] m_ar, m_au, m_br, m_bu;
  logic        [MW-1:0] bh_ru, bw_rr, bh_rr, bw_ru, ah_ru, aw_rr, ah_rr, aw_ru;
  logic        [HW-1:0] s3_aw, s3_ah, s3_bw, s3_bh;

  always_comb begin
    d_ar = QW'(dx_ac) + QW'(dy_as);
    d_au = QW'(dy_ac) - QW'(dx_as);
    d_br = QW'(dx_bc) + QW'(dy_bs);
    d_bu = QW'(dy_bc) - QW'(dx_bs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_ar  <= d_ar[QW-1] ? QW'(-d_ar) : QW'(d_ar);
      m_au  <= d_au[QW-1] ? QW'(-d_au) : QW'(d_au);
      m_br  <= d_br[QW-1] ? QW'(-d_br) : QW'(d_br);
      m_bu  <= d_bu[QW-1] ? QW'(-d_bu) : QW'(d_bu);
      bh_ru <= MW'(bh) * MW'(mag_ru);
      bw_rr <= MW'(bw) * MW'(mag_rr);
      bh_rr <= MW'(bh) * MW'(mag_rr);
      bw_ru <= MW'(bw) * MW'(mag_ru);
      ah_ru <= MW'(ah) * MW'(mag_ru);
      aw_rr <= MW'(aw) * MW'(mag_rr);
      ah_rr <= MW'(ah) * MW'(mag_rr);
      aw_ru <= MW'(aw) * MW'(mag_ru);
      s3_aw <= aw;
      s3_ah <= ah;
      s3_bw <= bw;
      s3_bh <= bh;
    end
  end

  // stage 4: both sides of each axis test, scaled to a common fraction
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lhs[0] <= CW'(m_ar) << AXIS_FRAC_BITS;
      lhs[1] <= CW'(m_au) << AXIS_FRAC_BITS;
      lhs[2] <= CW'(m_br) << AXIS_FRAC_BITS;
      lhs[3] <= CW'(m_bu) << AXIS_FRAC_BITS;
      rhs[0] <= CW'(bh_ru) + CW'(bw_rr) + (CW'(s3_aw) << (2 * AXIS_FRAC_BITS));
      rhs[1] <= CW'(bh_rr) + CW'(bw_ru) + (CW'(s3_ah) << (2 * AXIS_FRAC_BITS));
      rhs[2] <= CW'(ah_ru) + CW'(aw_rr) + (CW'(s3_bw) << (2 * AXIS_FRAC_BITS));
      rhs[3] <= CW'(ah_rr) + CW'(aw_ru) + (CW'(s3_bh) << (2 * AXIS_FRAC_BITS));
    end
  end

endmodule

### design/obb_decide.sv
module obb_decide #(
  parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
  parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    en,
  input  logic                                    in_valid,
  input  logic [COORD_WIDTH+2*AXIS_FRAC_BITS+5:0] lhs [4],
  input  logic [COORD_WIDTH+2*AXIS_FRAC_BITS+5:0] rhs [4],
  output logic                                    out_valid,
  output logic                                    overlap
);
  import obb_pkg::*;

  logic [3:0] sep;

  // touching counts as overlap, so only a strict excess separates
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sep[i] = lhs[i] > rhs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      overlap <= ~|sep;
    end
  end

endmodule

### design/oriented_box_overlap_test_top.sv
// oriented rectangle overlap test, separating axis form
//
// box_in carries one pair of rectangles per beat (center, unit right axis as
// cos/sin, half width and half height of each); result returns one beat per
// pair with overlap = 1 when none of the four box axes separates them.
// touching rectangles count as overlapping.
//
// five register stages: offset and axis products, offset projections, extent
// products, axis sums, compare. a result passes through them in that order,
// and one pair is taken every cycle while result drains.
// the rate is set by the pipeline itself; every multiplier has its own stage.
//
// reset clears every stage valid bit; nothing else is held between pairs.
// when the receiver holds ready low with a result waiting, the whole pipeline
// freezes and box_in.ready drops in the same cycle; nothing is dropped or
// repeated, and bubbles in the pipeline are kept in place.
module oriented_box_overlap_test_top #(
  parameter int COORD_WIDTH    = obb_pkg::COORD_WIDTH_DEF,
  parameter int AXIS_FRAC_BITS = obb_pkg::AXIS_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  obb_box_if.sink    box_in,
  obb_result_if.source result
);
  import obb_pkg::*;

  localparam int AW = AXIS_FRAC_BITS + 2;
  localparam int PW = COORD_WIDTH + 1 + AW;
  localparam int SW = 2 * AW + 1;
  localparam int HW = COORD_WIDTH - 1;
  localparam int CW = COORD_WIDTH + 2 * AW + 2;

  logic en;
  logic out_valid;

  // the whole pipe moves unless a finished beat is blocked at the output
  assign en           = !out_valid || result.ready;
  assign box_in.ready = en;
  assign result.valid = out_valid;

  logic                 v2;
  logic signed [PW-1:0] dx_ac, dy_as, dx_as, dy_ac, dx_bc, dy_bs, dx_bs, dy_bc;
  logic        [SW-1:0] mag_rr, mag_ru;
  logic        [HW-1:0] aw, ah, bw, bh;

  obb_front #(
    .COORD_WIDTH    (COORD_WIDTH),
    .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (box_in.valid),
    .a_x       (box_in.a_center_x),
    .a_y       (box_in.a_center_y),
    .a_cos     (box_in.a_axis_cos),
    .a_sin     (box_in.a_axis_sin),
    .a_w       (box_in.a_half_width),
    .a_h       (box_in.a_half_height),
    .b_x       (box_in.b_center_x),
    .b_y       (box_in.b_center_y),
    .b_cos     (box_in.b_axis_cos),
    .b_sin     (box_in.b_axis_sin),
    .b_w       (box_in.b_half_width),
    .b_h       (box_in.b_half_height),
    .out_valid (v2),
    .dx_ac     (dx_ac),
    .dy_as     (dy_as),
    .dx_as     (dx_as),
    .dy_ac     (dy_ac),
    .dx_bc     (dx_bc),
    .dy_bs     (dy_bs),
    .dx_bs     (dx_bs),
    .dy_bc     (dy_bc),
    .mag_rr    (mag_rr),
    .mag_ru    (mag_ru),
    .aw        (aw),
    .ah        (ah),
    .bw        (bw),
    .bh        (bh)
  );

  logic          v4;
  logic [CW-1:0] lhs [4];
  logic [CW-1:0] rhs [4];

  obb_extent #(
    .COORD_WIDTH    (COORD_WIDTH),
    .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
  ) u_extent (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .dx_ac     (dx_ac),
    .dy_as     (dy_as),
    .dx_as     (dx_as),
    .dy_ac     (dy_ac),
    .dx_bc     (dx_bc),
    .dy_bs     (dy_bs),
    .dx_bs     (dx_bs),
    .dy_bc     (dy_bc),
    .mag_rr    (mag_rr),
    .mag_ru    (mag_ru),
    .aw        (aw),
    .ah        (ah),
    .bw        (bw),
    .bh        (bh),
    .out_valid (v4),
    .lhs       (lhs),
    .rhs       (rhs)
  );

  obb_decide #(
    .COORD_WIDTH    (COORD_WIDTH),
    .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
  ) u_decide (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .lhs       (lhs),
    .rhs       (rhs),
    .out_valid (out_valid),
    .overlap   (result.overlap)
  );

endmodule

### tb/oriented_box_overlap_test_top_tb.sv
module oriented_box_overlap_test_top_tb;
  import obb_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int AF = AXIS_FRAC_BITS_DEF;
  localparam int AW = AF + 2;
  localparam int HW = CW - 1;
  localparam int UNIT = 1 << AF;
  localparam int DIAG = $rtoi(UNIT * 0.70710678 + 0.5);
  localparam int LSB_PER_UNIT = 256;
  localparam int MAX_CENTER = (1 << (CW - 1)) - 1;
  localparam int MIN_CENTER = -(1 << (CW - 1));
  localparam int MAX_HALF = (1 << HW) - 1;
  localparam int PHASES = 5;
  localparam int PAIRS_PER_PHASE = 250;
  localparam int PIPE_LATENCY = 4;
  localparam int LIMIT_CYCLES = 400000;

  typedef logic [127:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] a_center_x;
    logic signed [CW-1:0] a_center_y;
    logic signed [AW-1:0] a_axis_cos;
    logic signed [AW-1:0] a_axis_sin;
    logic        [HW-1:0] a_half_width;
    logic        [HW-1:0] a_half_height;
    logic signed [CW-1:0] b_center_x;
    logic signed [CW-1:0] b_center_y;
    logic signed [AW-1:0] b_axis_cos;
    logic signed [AW-1:0] b_axis_sin;
    logic        [HW-1:0] b_half_width;
    logic        [HW-1:0] b_half_height;
  } box_pair_t;

  class overlap_scoreboard;
    bit pending_overlap[$];
    int failures;
    int results_seen;

    function new();
      failures = 0;
      results_seen = 0;
    endfunction

    function wide_t mag(longint v);
      return (v < 0) ? wide_t'(-v) : wide_t'(v);
    endfunction

    // exact compare in Q.(8+2F): |d.u| * 2^F > h1*|p.u| + h2*|q.u| + h_own * 2^2F
    function bit axis_separates(longint d, wide_t h1, longint dot1,
                                wide_t h2, longint dot2, wide_t h_own);
      wide_t lhs;
      wide_t rhs;
      lhs = mag(d) << AF;
      rhs = h1 * mag(dot1) + h2 * mag(dot2) + (h_own << (2 * AF));
      return lhs > rhs;
    endfunction

    function bit overlap_of(box_pair_t p);
      longint a_cos, a_sin, b_cos, b_sin, dx, dy;
      longint a_w, a_h, b_w, b_h;
      longint rr, ru, ur, uu, d_ar, d_au, d_br, d_bu;
      bit sep;
      a_cos = p.a_axis_cos;
      a_sin = p.a_axis_sin;
      b_cos = p.b_axis_cos;
      b_sin = p.b_axis_sin;
      a_w = p.a_half_width;
      a_h = p.a_half_height;
      b_w = p.b_half_width;
      b_h = p.b_half_height;
      dx = longint'(p.a_center_x) - longint'(p.b_center_x);
      dy = longint'(p.a_center_y) - longint'(p.b_center_y);
      // up axis is (-sin, cos)
      rr = a_cos * b_cos + a_sin * b_sin;
      ru = a_sin * b_cos - a_cos * b_sin;
      ur = a_cos * b_sin - a_sin * b_cos;
      uu = a_sin * b_sin + a_cos * b_cos;
      d_ar = dx * a_cos + dy * a_sin;
      d_au = dy * a_cos - dx * a_sin;
      d_br = dx * b_cos + dy * b_sin;
      d_bu = dy * b_cos - dx * b_sin;
      sep = axis_separates(d_ar, b_h, ru, b_w, rr, a_w)
         || axis_separates(d_au, b_h, uu, b_w, ur, a_h)
         || axis_separates(d_br, a_h, ur, a_w, rr, b_w)
         || axis_separates(d_bu, a_h, uu, a_w, ru, b_h);
      return !sep;
    endfunction

    function void note_pair(box_pair_t p);
      pending_overlap.push_back(overlap_of(p));
    endfunction

    function void check_result(logic got);
      bit want;
      results_seen++;
      if (pending_overlap.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("result %0d: beat with no pair pending, overlap=%b", results_seen, got);
        return;
      end
      want = pending_overlap.pop_front();
      if (got !== want) begin
        failures++;
        if (failures <= 10)
          $display("result %0d: overlap expected %0b, got %b", results_seen, want, got);
      end
    endfunction

    function int pending();
      return pending_overlap.size();
    endfunction

    function void close_out();
      if (pending_overlap.size() != 0) begin
        $display("%0d results never arrived", pending_overlap.size());
        failures += pending_overlap.size();
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   idle_pct;
  int   stall_pct;
  overlap_scoreboard sb;

  obb_box_if    box_if ();
  obb_result_if res_if ();

  oriented_box_overlap_test_top uut (
    .clk   (clk),
    .rst   (rst),
    .box_in(box_if),
    .result(res_if)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * LIMIT_CYCLES);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic box_pair_t mk(int ax, int ay, int ac, int as_, int aw, int ah,
                                   int bx, int by, int bc, int bs, int bw, int bh);
    box_pair_t p;
    p.a_center_x    = CW'(ax);
    p.a_center_y    = CW'(ay);
    p.a_axis_cos    = AW'(ac);
    p.a_axis_sin    = AW'(as_);
    p.a_half_width  = HW'(aw);
    p.a_half_height = HW'(ah);
    p.b_center_x    = CW'(bx);
    p.b_center_y    = CW'(by);
    p.b_axis_cos    = AW'(bc);
    p.b_axis_sin    = AW'(bs);
    p.b_half_width  = HW'(bw);
    p.b_half_height = HW'(bh);
    return p;
  endfunction

  function automatic int spread(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic int random_extent();
    int r;
    r = $urandom_range(99);
    if (r < 80) return $urandom_range(0, 1 << 16);
    if (r < 95) return $urandom_range(0, 1 << 20);
    return $urandom_range(0, 1 << 21);
  endfunction

  function automatic void quarter_axis(output int c, output int s);
    case ($urandom_range(3))
      0: begin c = UNIT;  s = 0;     end
      1: begin c = 0;     s = UNIT;  end
      2: begin c = -UNIT; s = 0;     end
      default: begin c = 0; s = -UNIT; end
    endcase
  endfunction

  function automatic void unit_axis(output int c, output int s);
    c = int'($urandom_range(0, 2 * UNIT)) - UNIT;
    s = $rtoi($sqrt(real'(UNIT * UNIT - c * c)) + 0.5);
    if ($urandom_range(1)) s = -s;
  endfunction

  function automatic box_pair_t random_pair();
    box_pair_t p;
    int kind, ac, as_, bc, bs, aw, ah, bw, bh, ax, ay, dx, dy, xr, yr, lim, gap;
    kind = $urandom_range(99);
    if (kind < 15) begin
      // raw codes, every bit of every field
      p.a_center_x    = CW'($urandom);
      p.a_center_y    = CW'($urandom);
      p.a_axis_cos    = AW'($urandom);
      p.a_axis_sin    = AW'($urandom);
      p.a_half_width  = HW'($urandom);
      p.a_half_height = HW'($urandom);
      p.b_center_x    = CW'($urandom);
      p.b_center_y    = CW'($urandom);
      p.b_axis_cos    = AW'($urandom);
      p.b_axis_sin    = AW'($urandom);
      p.b_half_width  = HW'($urandom);
      p.b_half_height = HW'($urandom);
      return p;
    end
    aw = random_extent();
    ah = random_extent();
    bw = random_extent();
    bh = random_extent();
    ax = spread(1 << 21);
    ay = spread(1 << 21);
    if (kind < 35) begin
      // quarter-turned boxes set on the touching line, give or take one lsb
      quarter_axis(ac, as_);
      quarter_axis(bc, bs);
      xr = ((ac != 0) ? aw : ah) + ((bc != 0) ? bw : bh);
      yr = ((ac != 0) ? ah : aw) + ((bc != 0) ? bh : bw);
      gap = int'($urandom_range(0, 2)) - 1;
      if ($urandom_range(1)) begin
        dx = xr + gap;
        dy = spread(yr);
      end else begin
        dy = yr + gap;
        dx = spread(xr);
      end
      if ($urandom_range(1)) dx = -dx;
      if ($urandom_range(1)) dy = -dy;
    end else begin
      unit_axis(ac, as_);
      unit_axis(bc, bs);
      lim = 2 * (aw + ah + bw + bh) + 16;
      if (lim > (1 << 22)) lim = 1 << 22;
      dx = spread(lim);
      dy = spread(lim);
    end
    return mk(ax, ay, ac, as_, aw, ah, ax - dx, ay - dy, bc, bs, bw, bh);
  endfunction

  task automatic send_pair(box_pair_t p);
    while ($urandom_range(99) < idle_pct) begin
      box_if.valid <= 1'b0;
      @(posedge clk);
    end
    box_if.valid         <= 1'b1;
    box_if.a_center_x    <= p.a_center_x;
    box_if.a_center_y    <= p.a_center_y;
    box_if.a_axis_cos    <= p.a_axis_cos;
    box_if.a_axis_sin    <= p.a_axis_sin;
    box_if.a_half_width  <= p.a_half_width;
    box_if.a_half_height <= p.a_half_height;
    box_if.b_center_x    <= p.b_center_x;
    box_if.b_center_y    <= p.b_center_y;
    box_if.b_axis_cos    <= p.b_axis_cos;
    box_if.b_axis_sin    <= p.b_axis_sin;
    box_if.b_half_width  <= p.b_half_width;
    box_if.b_half_height <= p.b_half_height;
    @(posedge clk);
    while (!box_if.ready) @(posedge clk);
  endtask

  task automatic drain();
    box_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // input and result beats are both sampled here, before the edge updates
  always @(posedge clk) begin
    box_pair_t seen;
    if (!rst) begin
      if (box_if.valid && box_if.ready) begin
        seen.a_center_x    = box_if.a_center_x;
        seen.a_center_y    = box_if.a_center_y;
        seen.a_axis_cos    = box_if.a_axis_cos;
        seen.a_axis_sin    = box_if.a_axis_sin;
        seen.a_half_width  = box_if.a_half_width;
        seen.a_half_height = box_if.a_half_height;
        seen.b_center_x    = box_if.b_center_x;
        seen.b_center_y    = box_if.b_center_y;
        seen.b_axis_cos    = box_if.b_axis_cos;
        seen.b_axis_sin    = box_if.b_axis_sin;
        seen.b_half_width  = box_if.b_half_width;
        seen.b_half_height = box_if.b_half_height;
        sb.note_pair(seen);
      end
      if (res_if.valid && res_if.ready) sb.check_result(res_if.overlap);
    end
    res_if.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  initial begin
    box_pair_t corner_cases[$];
    int idle_tab[PHASES];
    int stall_tab[PHASES];
    idle_tab  = '{0, 84, 0, 9, 0};
    stall_tab = '{0, 0, 84, 9, 0};
    sb = new();
    idle_pct  = 0;
    stall_pct = 0;
    rst                  <= 1'b1;
    box_if.valid         <= 1'b0;
    box_if.a_center_x    <= '0;
    box_if.a_center_y    <= '0;
    box_if.a_axis_cos    <= '0;
    box_if.a_axis_sin    <= '0;
    box_if.a_half_width  <= '0;
    box_if.a_half_height <= '0;
    box_if.b_center_x    <= '0;
    box_if.b_center_y    <= '0;
    box_if.b_axis_cos    <= '0;
    box_if.b_axis_sin    <= '0;
    box_if.b_half_width  <= '0;
    box_if.b_half_height <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // degenerate: zero axes, zero extents, same center; then equal unit boxes on one center
    corner_cases.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    corner_cases.push_back(mk(0, 0, UNIT, 0, 256, 256, 0, 0, UNIT, 0, 256, 256));
    // touching edges count as overlap, one lsb apart does not
    corner_cases.push_back(mk(0, 0, UNIT, 0, 256, 256, 512, 0, UNIT, 0, 256, 256));
    corner_cases.push_back(mk(0, 0, UNIT, 0, 256, 256, 513, 0, UNIT, 0, 256, 256));
    corner_cases.push_back(mk(0, 0, UNIT, 0, 256, 128, 0, -428, 0, UNIT, 300, 50));
    corner_cases.push_back(mk(0, 0, UNIT, 0, 256, 128, 0, -429, 0, UNIT, 300, 50));
    // corners of the coordinate range, full extents: opposite corners, then one shared corner
    corner_cases.push_back(mk(MIN_CENTER, MIN_CENTER, UNIT, 0, MAX_HALF, MAX_HALF,
                              MAX_CENTER, MAX_CENTER, UNIT, 0, MAX_HALF, MAX_HALF));
    corner_cases.push_back(mk(MAX_CENTER, MAX_CENTER, UNIT, 0, MAX_HALF, MAX_HALF,
                              MAX_CENTER, MAX_CENTER, 0, UNIT, MAX_HALF, MAX_HALF));
    // out-of-range axis codes used as given, then boxes on negative unit axes
    corner_cases.push_back(mk(0, 0, -32768, 32767, 1000, 2000,
                              500, -700, 32767, -32768, 3000, 10));
    corner_cases.push_back(mk(MAX_CENTER, MAX_CENTER, 32767, 32767, MAX_HALF, MAX_HALF,
                              MAX_CENTER, MAX_CENTER, 32767, 32767, MAX_HALF, MAX_HALF));
    corner_cases.push_back(mk(MIN_CENTER, MIN_CENTER, -32768, -32768, 0, 0,
                              MIN_CENTER, MIN_CENTER, -32768, -32768, 0, 0));
    corner_cases.push_back(mk(0, 0, UNIT, UNIT, 256, 256, 768, 0, UNIT, 0, 256, 256));
    corner_cases.push_back(mk(100, -100, -UNIT, 0, 256, 512,
                              612, -100, 0, -UNIT, 256, 256));
    // point boxes
    corner_cases.push_back(mk(5, 5, UNIT, 0, 0, 0, 6, 5, UNIT, 0, 0, 0));
    corner_cases.push_back(mk(5, 5, DIAG, DIAG, 0, 0, 5, 5, -DIAG, DIAG, 0, 0));
    // containment and a cross with no corner inside the other box
    corner_cases.push_back(mk(0, 0, UNIT, 0, 25600, 25600, 2560, -5120, DIAG, DIAG, 768, 256));
    corner_cases.push_back(mk(0, 0, UNIT, 0, 12800, 256, 0, 0, 0, UNIT, 12800, 256));
    // thin diagonal box off a corner: only b's own axes separate, using b's extents
    corner_cases.push_back(mk(0, 0, UNIT, 0, 256, 256, 400, 400, DIAG, -DIAG, 1000, 10));
    corner_cases.push_back(mk(0, 0, UNIT, 0, 256, 256, 400, 400, DIAG, DIAG, 10, 1000));
    corner_cases.push_back(mk(0, 0, UNIT, 0, 256, 256, 400, 400, DIAG, -DIAG, 1000, 210));
    corner_cases.push_back(mk(0, 0, 0, 0, 256, 256, 2560, 0, UNIT, 0, 256, 256));
    corner_cases.push_back(mk(0, 0, UNIT, 0, MAX_HALF, 0, 0, 1, UNIT, 0, MAX_HALF, 0));

    foreach (corner_cases[i]) send_pair(corner_cases[i]);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      repeat (PAIRS_PER_PHASE) send_pair(random_pair());
      // sender holds off until every beat in flight has come back
      drain();
    end
    idle_pct  = 0;
    stall_pct = 0;

    repeat (2 * PIPE_LATENCY) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

### files.f
design/obb_pkg.sv
design/obb_box_if.sv
design/obb_front.sv
design/obb_extent.sv
design/obb_decide.sv
design/oriented_box_overlap_test_top.sv
tb/oriented_box_overlap_test_top_tb.sv
